// ===== hw/rtl/owp_pkg.sv =====
`timescale 1ns / 1ps

package owp_pkg;

   // Item field widths
   localparam int WEIGHT_BITS    = 16;
   localparam int PART_IDX_BITS  = 6;
   localparam int POINT_CNT_BITS = 11;
   localparam int CSR_BITS       = 7;

   // Packed channel widths (whole bytes)
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 24;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_MAX_PARTS  = 64;

   // Reset value of the part-count register
   localparam logic [CSR_BITS-1:0] NUM_PARTS_RESET = CSR_BITS'(1);

endpackage

// ===== hw/rtl/owp_ram.sv =====
`timescale 1ns / 1ps

module owp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/owp_chooser.sv =====
`timescale 1ns / 1ps

module owp_chooser #(
   parameter int TOT_W = 27,
   parameter int R_W   = 6
) (
   input  logic                        clock,
   input  logic                        ld,
   input  logic                        rank_nz,
   input  logic [R_W-1:0]              r,
   input  logic [TOT_W-1:0]            cur,
   input  logic [owp_pkg::WEIGHT_BITS-1:0] w,
   input  logic [TOT_W-1:0]            maxw,
   input  logic [TOT_W-1:0]            minw,
   input  logic [TOT_W-1:0]            tot,
   input  logic [TOT_W-1:0]            prefix,
   output logic                        stay
);

   localparam int PW = TOT_W + R_W;

   logic [TOT_W-1:0] cur_w;
   logic [PW-1:0]    mx_ff, mn_ff, c1_ff, c2_ff, a1_ff, a2_ff;
   logic             rnz_ff;
   logic [PW-1:0]    hi1, lo1, hi2, lo2, d1, d2;
   logic [PW-1:0]    h1a, l1a, h2a, l2a;

   assign cur_w = cur + TOT_W'(w);

   // Stage 1: scale max, min and current sums by the count of parts left.
   always_ff @(posedge clock) begin
      if (ld) begin
         mx_ff  <= PW'(maxw) * PW'(r);
         mn_ff  <= PW'(minw) * PW'(r);
         c1_ff  <= PW'(cur_w) * PW'(r);
         c2_ff  <= PW'(cur) * PW'(r);
         a1_ff  <= PW'(tot - (prefix + TOT_W'(w)));
         a2_ff  <= PW'(tot - prefix);
         rnz_ff <= rank_nz;
      end
   end

   // Stage 2: spread of each choice; earlier parts count only past part 0.
   always_comb begin
      h1a = (rnz_ff && mx_ff > c1_ff) ? mx_ff : c1_ff;
      l1a = (rnz_ff && mn_ff < c1_ff) ? mn_ff : c1_ff;
      h2a = (rnz_ff && mx_ff > c2_ff) ? mx_ff : c2_ff;
      l2a = (rnz_ff && mn_ff < c2_ff) ? mn_ff : c2_ff;
      hi1 = (h1a > a1_ff) ? h1a : a1_ff;
      lo1 = (l1a < a1_ff) ? l1a : a1_ff;
      hi2 = (h2a > a2_ff) ? h2a : a2_ff;
      lo2 = (l2a < a2_ff) ? l2a : a2_ff;
      d1  = hi1 - lo1;
      d2  = hi2 - lo2;
   end

   assign stay = (d1 <= d2);

endmodule

// ===== hw/rtl/ordered_weighted_partitioner.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload (low bit first)                         Marker
// req      in         tdata: weight[15:0]                             tlast: last_point
// rsp      out        tdata: part_index[5:0], point_count[16:6], 0    tlast: last_result
//                     tuser: error
// csr      in         wdata: num_parts[6:0], written when csr_we high
//
// Load: one weight per cycle into the weight memory.
// Split: each point takes a read state and a decide state, plus a compare
//   state when the spread compare is needed; the registered read port of the
//   weight memory and the registered multiply in front of the compare set these steps.
// Emit: each part count is read from the part-count memory, then handed to the result register once it is free.
// Reset is synchronous; no clearing pass is needed. The result register
//   holds an item under rsp_tready low while loading of the next run goes on.

module ordered_weighted_partitioner #(
   parameter int MAX_POINTS = owp_pkg::DEF_MAX_POINTS,
   parameter int MAX_PARTS  = owp_pkg::DEF_MAX_PARTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [owp_pkg::REQ_DATA_BITS-1:0] req_tdata,  // weight
   input  logic                              req_tlast,  // last_point
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [owp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // part_index, point_count, zero fill
   output logic                              rsp_tuser,  // error
   output logic                              rsp_tlast,  // last_result
   input  logic                              csr_we,
   input  logic [owp_pkg::CSR_BITS-1:0]      csr_wdata   // num_parts
);

   localparam int WB     = owp_pkg::WEIGHT_BITS;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int AW     = $clog2(MAX_POINTS);
   localparam int RANK_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int PART_W = $clog2(MAX_PARTS + 1);
   localparam int TW     = WB + CNT_W;

   localparam logic [3:0] S_LOAD    = 4'd0;
   localparam logic [3:0] S_CHECK   = 4'd1;
   localparam logic [3:0] S_INIT_RD = 4'd2;
   localparam logic [3:0] S_INIT    = 4'd3;
   localparam logic [3:0] S_RD      = 4'd4;
   localparam logic [3:0] S_EV      = 4'd5;
   localparam logic [3:0] S_CMP     = 4'd6;
   localparam logic [3:0] S_FIN     = 4'd7;
   localparam logic [3:0] S_ERD     = 4'd8;
   localparam logic [3:0] S_EWT     = 4'd9;

   logic [3:0]                  state_ff, state_in;
   logic [owp_pkg::CSR_BITS-1:0] num_parts_ff, num_parts_in;
   logic [CNT_W-1:0]            loaded_ff, loaded_in;
   logic                        overflow_ff, overflow_in;
   logic [TW-1:0]               total_ff, total_in;
   logic [PART_W-1:0]           parts_ff, parts_in;
   logic [CNT_W-1:0]            i_ff, i_in;
   logic [RANK_W-1:0]           rank_ff, rank_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [TW-1:0]               cur_ff, cur_in;
   logic [TW-1:0]               prefix_ff, prefix_in;
   logic [TW-1:0]               maxw_ff, maxw_in;
   logic [TW-1:0]               minw_ff, minw_in;
   logic [WB-1:0]               w_ff, w_in;
   logic [RANK_W-1:0]           k_ff, k_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [owp_pkg::PART_IDX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [owp_pkg::POINT_CNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                        rsp_error_ff, rsp_error_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic            req_acc;
   logic            store_full;
   logic [WB-1:0]   req_w;
   logic [WB-1:0]   wt_rdata;
   logic            pc_we;
   logic [CNT_W-1:0] pc_rdata;
   logic            out_free;
   logic [PART_W-1:0] parts_sel;
   logic            last_rank;
   logic            forced;
   logic            quick_stay;
   logic            point_done;
   logic [RANK_W-1:0] r_left;
   logic            ld_cmp;
   logic            stay;
   logic [TW-1:0]   cur_plus;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign store_full = (32'(loaded_ff) == 32'(MAX_POINTS));
   assign req_w      = req_tdata[WB-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Weight store: written while loading, read once per point while splitting.
   owp_ram #(
      .WIDTH (WB),
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (req_acc && !store_full),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data (req_w),
      .rd_addr (i_ff[AW-1:0]),
      .rd_data (wt_rdata)
   );

   // Part counts: each part written once when it closes, read back to emit.
   owp_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_PARTS),
      .AW    (RANK_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (pc_we),
      .wr_addr (rank_ff),
      .wr_data (count_ff),
      .rd_addr (k_ff),
      .rd_data (pc_rdata)
   );

   // Clamp the configured count: zero acts as one, above range acts as the maximum.
   always_comb begin
      if (num_parts_ff == '0) begin
         parts_sel = PART_W'(1);
      end else if (32'(num_parts_ff) > 32'(MAX_PARTS)) begin
         parts_sel = PART_W'(MAX_PARTS);
      end else begin
         parts_sel = PART_W'(num_parts_ff);
      end
   end

   // Decision terms for the point now on the weight memory's read port.
   assign last_rank  = (32'(rank_ff) + 32'd1 == 32'(parts_ff));
   assign forced     = (32'(loaded_ff) - 32'(i_ff) ==
                        32'(parts_ff) - 32'(rank_ff) - 32'd1);
   assign cur_plus   = cur_ff + TW'(wt_rdata);
   assign quick_stay = (rank_ff != '0) && (cur_plus <= maxw_ff);
   assign point_done = (32'(i_ff) + 32'd1 == 32'(loaded_ff));
   assign r_left     = RANK_W'(32'(parts_ff) - 32'(rank_ff) - 32'd1);
   assign ld_cmp     = (state_ff == S_EV) && !last_rank && !forced && !quick_stay;

   owp_chooser #(
      .TOT_W (TW),
      .R_W   (RANK_W)
   ) u_chooser (
      .clock   (clock),
      .ld      (ld_cmp),
      .rank_nz (rank_ff != '0),
      .r       (r_left),
      .cur     (cur_ff),
      .w       (wt_rdata),
      .maxw    (maxw_ff),
      .minw    (minw_ff),
      .tot     (total_ff),
      .prefix  (prefix_ff),
      .stay    (stay)
   );

   always_comb begin
      state_in     = state_ff;
      num_parts_in = csr_we ? csr_wdata : num_parts_ff;
      loaded_in    = loaded_ff;
      overflow_in  = overflow_ff;
      total_in     = total_ff;
      parts_in     = parts_ff;
      i_in         = i_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      prefix_in    = prefix_ff;
      maxw_in      = maxw_ff;
      minw_in      = minw_ff;
      w_in         = w_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_error_in = rsp_error_ff;
      rsp_last_in  = rsp_last_ff;
      pc_we        = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            // Store the weight, or flag overflow once the store is full.
            if (req_acc) begin
               if (store_full) begin
                  overflow_in = 1'b1;
               end else begin
                  loaded_in = loaded_ff + CNT_W'(1);
                  total_in  = total_ff + TW'(req_w);
               end
               if (req_tlast) begin
                  state_in = S_CHECK;
               end
            end
         end

         S_CHECK: begin
            if (overflow_ff || (32'(loaded_ff) < 32'(parts_sel))) begin
               // Error run: a single item, then drop the run.
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_count_in = '0;
                  rsp_error_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  loaded_in    = '0;
                  overflow_in  = 1'b0;
                  total_in     = '0;
                  state_in     = S_LOAD;
               end
            end else begin
               parts_in = parts_sel;
               i_in     = '0;
               state_in = S_INIT_RD;
            end
         end

         S_INIT_RD: begin
            state_in = S_INIT;
         end

         S_INIT: begin
            // First point always opens part 0.
            cur_in    = TW'(wt_rdata);
            prefix_in = TW'(wt_rdata);
            count_in  = CNT_W'(1);
            rank_in   = '0;
            maxw_in   = '0;
            minw_in   = '0;
            i_in      = CNT_W'(1);
            state_in  = (32'(loaded_ff) == 32'd1) ? S_FIN : S_RD;
         end

         S_RD: begin
            state_in = S_EV;
         end

         S_EV: begin
            w_in = wt_rdata;
            if (last_rank) begin
               count_in = count_ff + CNT_W'(1);
            end else if (forced) begin
               // Just enough points left: every one opens a new part.
               pc_we    = 1'b1;
               rank_in  = rank_ff + RANK_W'(1);
               count_in = CNT_W'(1);
            end else if (quick_stay) begin
               cur_in   = cur_plus;
               count_in = count_ff + CNT_W'(1);
            end
            if (ld_cmp) begin
               state_in = S_CMP;
            end else begin
               prefix_in = prefix_ff + TW'(wt_rdata);
               i_in      = i_ff + CNT_W'(1);
               state_in  = point_done ? S_FIN : S_RD;
            end
         end

         S_CMP: begin
            if (stay) begin
               cur_in   = cur_ff + TW'(w_ff);
               count_in = count_ff + CNT_W'(1);
            end else begin
               // Close the current part and fold it into the earlier max and min.
               if (rank_ff == '0) begin
                  maxw_in = cur_ff;
                  minw_in = cur_ff;
               end else begin
                  maxw_in = (cur_ff > maxw_ff) ? cur_ff : maxw_ff;
                  minw_in = (cur_ff < minw_ff) ? cur_ff : minw_ff;
               end
               pc_we    = 1'b1;
               rank_in  = rank_ff + RANK_W'(1);
               cur_in   = TW'(w_ff);
               count_in = CNT_W'(1);
            end
            prefix_in = prefix_ff + TW'(w_ff);
            i_in      = i_ff + CNT_W'(1);
            state_in  = point_done ? S_FIN : S_RD;
         end

         S_FIN: begin
            pc_we    = 1'b1;
            k_in     = '0;
            state_in = S_ERD;
         end

         S_ERD: begin
            state_in = S_EWT;
         end

         S_EWT: begin
            // Hand one part count to the result register when it frees up.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = owp_pkg::PART_IDX_BITS'(k_ff);
               rsp_count_in = owp_pkg::POINT_CNT_BITS'(pc_rdata);
               rsp_error_in = 1'b0;
               rsp_last_in  = (32'(k_ff) + 32'd1 == 32'(parts_ff));
               if (32'(k_ff) + 32'd1 == 32'(parts_ff)) begin
                  loaded_in   = '0;
                  overflow_in = 1'b0;
                  total_in    = '0;
                  state_in    = S_LOAD;
               end else begin
                  k_in     = k_ff + RANK_W'(1);
                  state_in = S_ERD;
               end
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         num_parts_ff <= owp_pkg::NUM_PARTS_RESET;
         loaded_ff    <= '0;
         overflow_ff  <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_parts_ff <= num_parts_in;
         loaded_ff    <= loaded_in;
         overflow_ff  <= overflow_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      parts_ff     <= parts_in;
      i_ff         <= i_in;
      rank_ff      <= rank_in;
      count_ff     <= count_in;
      cur_ff       <= cur_in;
      prefix_ff    <= prefix_in;
      maxw_ff      <= maxw_in;
      minw_ff      <= minw_in;
      w_ff         <= w_in;
      k_ff         <= k_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      rsp_error_ff <= rsp_error_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = owp_pkg::RSP_DATA_BITS'({rsp_count_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_error_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
